// File: src/idrq_pkg.sv
// Package for the int8 dot-product requantize core.
// Holds the config register struct and reset values, register indexes,
// sequencer states and the request format of the shared multiply-add unit.
package idrq_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MULTIPLIER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_SHIFT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAKY_ENABLE     = 2'd2;

  // Reset values
  localparam logic [31:0] SCALE_MULTIPLIER_RST = 32'd65536;
  localparam logic [4:0]  SCALE_SHIFT_RST      = 5'd16;
  localparam logic        LEAKY_ENABLE_RST     = 1'b1;

  // Leaky slope and output range
  localparam int unsigned  LEAKY_SHIFT = 3;
  localparam logic [7:0]   Q_MAX       = 8'sd127;
  localparam logic [7:0]   Q_MIN       = 8'h80;

  typedef struct packed {
    logic [31:0] scale_multiplier;
    logic [4:0]  scale_shift;
    logic        leaky_enable;
  } cfg_t;

  // One request to the shared multiply-add unit:
  // result = addend + ((op_a * op_b) << (hi_half ? 16 : 0))
  typedef struct packed {
    logic signed [31:0] op_a;
    logic signed [16:0] op_b;
    logic        [63:0] addend;
    logic               hi_half;
  } mac_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_BIAS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_OUT
  } seq_state_t;

endpackage

// File: src/idrq_cfg_regs.sv
// Configuration registers of the int8 dot-product requantize core.
// Depends on idrq_pkg for register indexes, reset values and cfg_t.
module idrq_cfg_regs import idrq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Writes to an unknown index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_multiplier <= SCALE_MULTIPLIER_RST;
      cfg.scale_shift      <= SCALE_SHIFT_RST;
      cfg.leaky_enable     <= LEAKY_ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE_MULTIPLIER: cfg.scale_multiplier <= cfg_data;
        REG_SCALE_SHIFT:      cfg.scale_shift      <= cfg_data[4:0];
        REG_LEAKY_ENABLE:     cfg.leaky_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/idrq_mul_add.sv
// Shared multiply-add unit: one 32x17 signed multiply plus a 64-bit add.
// Depends on idrq_pkg for the mac_req_t request format.
module idrq_mul_add import idrq_pkg::*; (
  input  mac_req_t    req,
  output logic [63:0] result
);

  logic signed [48:0] prod;
  logic        [63:0] prod_ext;
  logic        [63:0] prod_pos;

  always_comb begin
    prod     = req.op_a * req.op_b;
    prod_ext = {{15{prod[48]}}, prod};
    // Upper half of a split multiply lands 16 bits up; overflow past 64 wraps
    prod_pos = req.hi_half ? {prod_ext[47:0], 16'b0} : prod_ext;
    result   = req.addend + prod_pos;
  end

endmodule

// File: src/int8_dot_product_requantize_core.sv
// int8 dot product with bias, leaky ReLU and requantization, top level.
// A non-last item is accepted and accumulated; a last item then runs bias add,
// the scale multiply and output, all on one shared 32x17 multiply-add unit
// used for accumulate, bias add and two halves of the 32x32 scale multiply.
// A new item is taken only in idle; the output step waits on m_tready.
// Reset (rst, synchronous): clears the sum, empties the output, loads config.
module int8_dot_product_requantize_core import idrq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [47:0]            s_tdata,  // weight_value, activation_value, bias_value
  input  logic                   s_tlast,  // last_element
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,  // quantized_result
  // Config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  seq_state_t  state, state_next;
  mac_req_t    req;
  logic [63:0] unit_result;

  logic signed [7:0]  weight;
  logic signed [7:0]  activation;
  logic        [31:0] bias;
  logic               last;
  logic        [31:0] running_sum;
  logic        [31:0] acc;
  logic        [63:0] prod;

  logic        [31:0] biased;
  logic        [31:0] leaky_val;
  logic signed [63:0] shifted;
  logic        [7:0]  sat_q;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  idrq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  idrq_mul_add u_unit (
    .req    (req),
    .result (unit_result)
  );

  // Operand select for the shared unit
  always_comb begin
    req = '0;
    unique case (state)
      ST_MAC: begin
        req.op_a   = {{24{weight[7]}}, weight};
        req.op_b   = {{9{activation[7]}}, activation};
        req.addend = {{32{running_sum[31]}}, running_sum};
      end
      ST_BIAS: begin
        req.op_a   = bias;
        req.op_b   = 17'sd1;
        req.addend = {{32{acc[31]}}, acc};
      end
      ST_MUL_LO: begin
        req.op_a   = acc;
        req.op_b   = {1'b0, cfg.scale_multiplier[15:0]};
      end
      ST_MUL_HI: begin
        req.op_a    = acc;
        req.op_b    = {1'b0, cfg.scale_multiplier[31:16]};
        req.addend  = prod;
        req.hi_half = 1'b1;
      end
      default: ;
    endcase
  end

  // Leaky step and final shift / saturate
  always_comb begin
    biased    = unit_result[31:0];
    leaky_val = (cfg.leaky_enable && biased[31]) ?
                32'($signed(biased) >>> LEAKY_SHIFT) : biased;
    shifted   = $signed(prod) >>> cfg.scale_shift;
    if (shifted > 64'sd127) begin
      sat_q = Q_MAX;
    end else if (shifted < -64'sd128) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = shifted[7:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MAC;
      ST_MAC:    state_next = last ? ST_BIAS : ST_IDLE;
      ST_BIAS:   state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Input capture and working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      weight     <= s_tdata[7:0];
      activation <= s_tdata[15:8];
      bias       <= s_tdata[47:16];
      last       <= s_tlast;
    end
    if (state == ST_MAC && last) begin
      acc <= unit_result[31:0];
    end
    if (state == ST_BIAS) begin
      acc <= leaky_val;
    end
    if (state == ST_MUL_LO || state == ST_MUL_HI) begin
      prod <= unit_result;
    end
  end

  // Running sum, cleared on the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (state == ST_MAC) begin
      running_sum <= last ? 32'd0 : unit_result[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= sat_q;
    end
  end

  // Checks
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && last) |=> (running_sum == 32'd0))
    else $error("running sum not cleared after last item");

  a_no_result_mid_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && !last) |=> (state == ST_IDLE))
    else $error("non-last item did not return to idle");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result appeared outside output step");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input ready while sequencer busy");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for int8_dot_product_requantize_core.
// Drives int8 pairs and biases as streamed requests, predicts the requantized
// results in-line and compares them; needs idrq_pkg and the core only.
`timescale 1ns / 100ps

module testbench;
  import idrq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;   // extra wait once all results are back
  localparam int ITEM_TARGET   = 850;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed step: either a request on the input stream or a config write
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [31:0]            data;
    logic signed [7:0]      w;
    logic signed [7:0]      a;
    logic [31:0]            bias;
    logic                   last;
    logic                   typed;
    logic signed [7:0]      want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata  = '0;  // weight_value, activation_value, bias_value
  logic                   s_tlast  = 1'b0; // last_element
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;  // quantized_result
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Mirror of the core's state and config
  logic [31:0] dot_sum;
  logic [31:0] mult_m;
  logic [4:0]  shift_m;
  logic        leaky_m;

  logic [7:0]  pending_quant[$];
  stim_row_t   directed[$];

  int  items_sent;
  int  results_seen;
  int  cfg_settings;
  int  mismatch_count;
  bit  steady_flow;

  int8_dot_product_requantize_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results still pending", pending_quant.size());
    $display("int8_dot_product_requantize_core: mismatch");
    $finish;
  end

  // Leaky slope, 64-bit exact scale, arithmetic shift, saturate to int8
  function automatic logic [7:0] requantize(input logic [31:0] biased);
    logic signed [31:0] s;
    logic signed [63:0] s64;
    logic signed [63:0] m64;
    logic signed [63:0] shifted;
    logic [7:0]         q;
    s = biased;
    if (leaky_m && s[31]) s = s >>> LEAKY_SHIFT;
    s64 = 64'(s);
    m64 = {32'h0, mult_m};
    shifted = (s64 * m64) >>> shift_m;
    if (shifted > 64'sd127) q = Q_MAX;
    else if (shifted < -64'sd128) q = Q_MIN;
    else q = shifted[7:0];
    return q;
  endfunction

  function automatic stim_row_t item_row(input logic signed [7:0] w, input logic signed [7:0] a,
                                         input logic [31:0] bias, input logic last,
                                         input logic typed, input logic signed [7:0] want);
    stim_row_t r;
    r = '{ROW_ITEM, REG_UNUSED, 32'h0, w, a, bias, last, typed, want};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [31:0] data);
    stim_row_t r;
    r = '{ROW_CFG, idx, data, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 8'sd0};
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed = {directed, r};
  endfunction

  // Send one request, then update the mirrored sum once it is taken; a last item queues its expected result
  task automatic send_pair(input logic signed [7:0] w, input logic signed [7:0] a,
                           input logic [31:0] bias, input logic last,
                           input logic typed, input logic signed [7:0] want);
    logic signed [31:0] w32;
    logic signed [31:0] a32;
    logic [31:0]        sum_next;
    logic [7:0]         quant;
    if (!steady_flow && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bias, a, w};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    w32 = 32'(w);
    a32 = 32'(a);
    sum_next = dot_sum + w32 * a32;
    if (last) begin
      quant = typed ? want : requantize(sum_next + bias);
      pending_quant = {pending_quant, quant};
      dot_sum = '0;
    end else begin
      dot_sum = sum_next;
    end
  endtask

  task automatic wait_results();
    while (pending_quant.size() != 0) @(posedge clk);
  endtask

  // Stop sending and let the core go idle before touching config
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE_MULTIPLIER: mult_m  = data;
      REG_SCALE_SHIFT:      shift_m = data[4:0];
      REG_LEAKY_ENABLE:     leaky_m = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One random dot product: mostly short, sometimes long, bias mostly small
  task automatic send_dot_product();
    int          len;
    int          pick;
    logic [31:0] bias;
    len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) bias = $urandom_range(8000) - 4000;
      else if (pick < 90) bias = $urandom;
      else bias = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      send_pair(8'($urandom), 8'($urandom), bias, i == len - 1, 1'b0, 8'sd0);
    end
  endtask

  // New random setting; upper data bits carry junk to check truncation
  task automatic random_config();
    int          pick;
    logic [4:0]  shift_sel;
    logic [31:0] mult_sel;
    shift_sel = $urandom_range(3) == 0 ? ($urandom_range(1) ? 5'd0 : 5'd31) : 5'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      if (shift_sel >= 6) mult_sel = $urandom_range((32'd1 << shift_sel) >> 6);
      else mult_sel = $urandom_range(2);
    end else if (pick < 80) begin
      mult_sel = $urandom;
    end else if (pick < 90) begin
      mult_sel = 32'h0;
    end else begin
      mult_sel = 32'hFFFF_FFFF;
    end
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
    write_reg(REG_SCALE_SHIFT, {27'($urandom), shift_sel});
    write_reg(REG_SCALE_MULTIPLIER, mult_sel);
    write_reg(REG_LEAKY_ENABLE, {31'($urandom), 1'($urandom_range(1))});
    cfg_settings++;
  endtask

  // Result side: random back-pressure, in-order compare
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        results_seen++;
        if (pending_quant.size() == 0) begin
          $error("unexpected result: quantized_result actual %0d", $signed(m_tdata));
          mismatch_count++;
        end else begin
          if (m_tdata !== pending_quant[0]) begin
            $error("quantized_result: expected %0d, actual %0d",
                   $signed(pending_quant[0]), $signed(m_tdata));
            mismatch_count++;
          end
          void'(pending_quant.pop_front());
        end
      end
      m_tready <= steady_flow || ($urandom_range(99) >= 15);
    end
  end

  // Main stimulus
  initial begin
    int phase;
    dot_sum = '0;
    mult_m  = SCALE_MULTIPLIER_RST;
    shift_m = SCALE_SHIFT_RST;
    leaky_m = LEAKY_ENABLE_RST;
    items_sent = 0;
    results_seen = 0;
    cfg_settings = 1;
    mismatch_count = 0;
    steady_flow = 1'b0;

    // Reset-time setting: scale is unity, negatives divided by 8
    add_row(item_row(8'sd1, 8'sd1, 32'd0, 1'b1, 1'b1, 8'sd1));
    add_row(item_row(8'sd127, 8'sd127, 32'd0, 1'b1, 1'b1, Q_MAX));
    add_row(item_row(-8'sd128, -8'sd128, 32'd0, 1'b1, 1'b1, Q_MAX));
    add_row(item_row(-8'sd128, 8'sd127, 32'd0, 1'b1, 1'b1, Q_MIN));
    add_row(item_row(8'sd0, 8'sd0, -32'sd8, 1'b1, 1'b1, -8'sd1));
    add_row(item_row(8'sd0, 8'sd0, -32'sd1, 1'b1, 1'b1, -8'sd1));
    add_row(item_row(8'sd0, 8'sd0, 32'd100, 1'b1, 1'b1, 8'sd100));
    // bias add wraps past the top into a negative sum
    add_row(item_row(8'sd1, 8'sd1, 32'h7FFF_FFFF, 1'b1, 1'b1, Q_MIN));
    add_row(item_row(8'sd0, 8'sd0, 32'h8000_0000, 1'b1, 1'b1, Q_MIN));
    // bias on non-last requests is ignored
    add_row(item_row(8'sd5, 8'sd6, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'sd0));
    add_row(item_row(-8'sd3, 8'sd7, 32'h1234_5678, 1'b0, 1'b0, 8'sd0));
    add_row(item_row(8'sd2, -8'sd2, 32'd10, 1'b1, 1'b1, 8'sd15));
    // write to an unknown index must change nothing
    add_row(cfg_row(REG_UNUSED, 32'h0));
    add_row(item_row(8'sd0, 8'sd0, 32'd50, 1'b1, 1'b1, 8'sd50));
    // extremes: no shift, no leaky, largest multiplier; junk in upper bits
    add_row(cfg_row(REG_SCALE_SHIFT, 32'hFFFF_FFE0));
    add_row(cfg_row(REG_LEAKY_ENABLE, 32'hFFFF_FFFE));
    add_row(cfg_row(REG_SCALE_MULTIPLIER, 32'hFFFF_FFFF));
    add_row(item_row(8'sd0, 8'sd0, 32'd0, 1'b1, 1'b1, 8'sd0));
    add_row(item_row(8'sd1, 8'sd1, 32'd0, 1'b1, 1'b1, Q_MAX));
    add_row(item_row(8'sd0, 8'sd0, 32'hFFFF_FFFF, 1'b1, 1'b1, Q_MIN));
    add_row(cfg_row(REG_SCALE_MULTIPLIER, 32'h0));
    add_row(item_row(8'sd127, 8'sd127, 32'h7FFF_FFFF, 1'b1, 1'b1, 8'sd0));
    // widest product, largest shift, leaky back on
    add_row(cfg_row(REG_SCALE_SHIFT, 32'h0000_001F));
    add_row(cfg_row(REG_SCALE_MULTIPLIER, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_LEAKY_ENABLE, 32'h1));
    add_row(item_row(8'sd0, 8'sd0, 32'h8000_0000, 1'b1, 1'b0, 8'sd0));
    add_row(item_row(8'sd0, 8'sd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 8'sd0));
    add_row(item_row(-8'sd128, -8'sd128, 32'd0, 1'b0, 1'b0, 8'sd0));
    add_row(item_row(-8'sd128, -8'sd128, -32'sd5, 1'b1, 1'b0, 8'sd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(directed[i].idx, directed[i].data);
        cfg_settings++;
      end else begin
        send_pair(directed[i].w, directed[i].a, directed[i].bias, directed[i].last,
                  directed[i].typed, directed[i].want);
      end
    end

    // Random phases, each under its own setting
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      random_config();
      steady_flow = (phase == 2);
      for (int d = $urandom_range(4, 12); d > 0; d--) begin
        send_dot_product();
        // hold off once until every result is back
        if (phase == 1 && d == 2) begin
          s_tvalid <= 1'b0;
          wait_results();
        end
      end
      phase++;
    end
    steady_flow = 1'b0;

    s_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pairs, checked %0d requantized results across %0d config settings",
             items_sent, results_seen, cfg_settings);
    if (mismatch_count == 0) begin
      $display("int8_dot_product_requantize_core: match");
    end else begin
      $display("int8_dot_product_requantize_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
src/idrq_pkg.sv
src/idrq_cfg_regs.sv
src/idrq_mul_add.sv
src/int8_dot_product_requantize_core.sv
tb/testbench.sv
